@@ hdl/llm_pkg.sv @@
// llm_pkg: shared constants, opcodes and helpers for the linked list manager
// no dependencies; imported by linked_list_manager
`default_nettype none

package llm_pkg;

    // node pool size; node numbers are ID_W bits wide, so the pool holds at most 2**ID_W
    localparam int NODE_SLOTS = 256;
    localparam int ID_W       = 8;
    localparam int CNT_W      = 9;
    localparam int OP_W       = 3;
    localparam int SLOT_AW    = $clog2(NODE_SLOTS);

    typedef enum logic [OP_W-1:0] {
        OP_APPEND  = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_SUCC    = 3'd2,
        OP_HEAD    = 3'd3,
        OP_TAIL    = 3'd4,
        OP_CLEAR   = 3'd5
    } llm_op_t;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    function automatic logic in_pool(input logic [ID_W-1:0] id);
        return 32'(id) < NODE_SLOTS;
    endfunction

    function automatic logic [SLOT_AW-1:0] slot_of(input logic [ID_W-1:0] id);
        return id[SLOT_AW-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/llm_ram.sv @@
// llm_ram: generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module llm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/linked_list_manager.sv @@
// linked_list_manager: singly linked list over a numbered node pool, top level
// depends on llm_pkg and llm_ram
`default_nettype none

// One singly linked list is kept over node numbers 0 to NODE_SLOTS-1. Each
// request (opcode, node_id) gives exactly one result transfer carrying status,
// node_out, node_out_valid and the list count after the request. Next links
// and membership bits live in two rams, each with one write port and one
// registered read port; head, tail and count sit in flip-flops. After reset
// the block sweeps the membership ram to zero and holds s_ready low until
// the sweep ends. Read head, read tail, unused opcodes and removal from an
// empty list load the result register on the accepting edge; append,
// successor, removal of the head and any request that fails on membership
// wait on one ram read; removal of any other node walks from the head, each
// walk step waiting on one link read, and passes at most count list positions
// before the predecessor is found or the chain ends; clear zeroes head, tail
// and count at once but sweeps the membership ram, so its result comes once
// the sweep ends. One request is in flight at a time; a new input transfer
// is taken once the previous one is finished and the output register is
// empty or draining in the same cycle.

module linked_list_manager (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // request channel
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [llm_pkg::OP_W-1:0]  s_opcode,
    input  wire logic [llm_pkg::ID_W-1:0]  s_node_id,
    // result channel
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_status,
    output logic      [llm_pkg::ID_W-1:0]  m_node_out,
    output logic                           m_node_out_valid,
    output logic      [llm_pkg::CNT_W-1:0] m_list_count
);

    import llm_pkg::*;

    // controller states
    typedef enum logic [6:0] {
        ST_INIT = 7'b0000001,  // membership sweep after reset
        ST_IDLE = 7'b0000010,  // waiting for a request
        ST_APND = 7'b0000100,  // membership bit of the appended node arriving
        ST_LINK = 7'b0001000,  // membership bit and link of the node arriving
        ST_WALK = 7'b0010000,  // walk step: test bounds, read link of p
        ST_CMP  = 7'b0100000,  // walk step: compare link of p with the node
        ST_CLR  = 7'b1000000   // membership sweep for clear
    } state_t;

    state_t state_reg, state_next;

    // request held for multi-cycle operations
    logic [OP_W-1:0]  op_reg, op_next;
    logic [ID_W-1:0]  id_reg, id_next;

    // list state
    logic [ID_W-1:0]       head_reg, head_next;
    logic [ID_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    // membership sweep address
    logic [SLOT_AW-1:0]    sweep_reg, sweep_next;

    // walk state: current node, steps taken, link of the node being removed
    logic [ID_W-1:0]  p_reg, p_next;
    logic [CNT_W-1:0] steps_reg, steps_next;
    logic [ID_W-1:0]  id_link_reg, id_link_next;

    // result register
    logic             m_valid_reg, m_valid_next;
    logic             m_status_reg, m_status_next;
    logic [ID_W-1:0]  m_node_out_reg, m_node_out_next;
    logic             m_node_out_valid_reg, m_node_out_valid_next;
    logic [CNT_W-1:0] m_list_count_reg, m_list_count_next;

    // link memory ports
    logic               ram_we;
    logic [SLOT_AW-1:0] ram_waddr;
    logic [ID_W-1:0]    ram_wdata;
    logic               ram_re;
    logic [SLOT_AW-1:0] ram_raddr;
    logic [ID_W-1:0]    ram_rdata;

    // membership memory ports
    logic               mem_we;
    logic [SLOT_AW-1:0] mem_waddr;
    logic               mem_wdata;
    logic               mem_re;
    logic [SLOT_AW-1:0] mem_raddr;
    logic               mem_rdata;

    // result produced this cycle
    logic            res_load;
    logic            res_fail;
    logic [ID_W-1:0] res_node;
    logic            res_node_valid;
    logic            rm_done;
    logic            s_xfer;
    logic            req_member;

    llm_ram #(
        .WIDTH (ID_W),
        .DEPTH (NODE_SLOTS)
    ) u_link_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // membership bits are read only when idle and written only while busy,
    // so accesses to one entry never overlap
    llm_ram #(
        .WIDTH (1),
        .DEPTH (NODE_SLOTS)
    ) u_member_ram (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // take a request only when idle and the output register is free or draining
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_xfer  = s_valid && s_ready;

    // membership of the held request node, valid in the cycle after the read
    assign req_member = in_pool(id_reg) && mem_rdata;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        sweep_next   = sweep_reg;
        p_next       = p_reg;
        steps_next   = steps_reg;
        id_link_next = id_link_reg;

        ram_we    = 1'b0;
        ram_waddr = slot_of(tail_reg);
        ram_wdata = id_reg;
        ram_re    = 1'b0;
        ram_raddr = slot_of(s_node_id);

        mem_we    = 1'b0;
        mem_waddr = slot_of(id_reg);
        mem_wdata = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = slot_of(s_node_id);

        res_load       = 1'b0;
        res_fail       = STATUS_FAIL;
        res_node       = '0;
        res_node_valid = 1'b0;
        rm_done        = 1'b0;

        unique case (state_reg)
            ST_INIT, ST_CLR: begin
                // zero one membership bit per cycle
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = 1'b0;
                sweep_next = sweep_reg + SLOT_AW'(1);
                if (sweep_reg == SLOT_AW'(NODE_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                    if (state_reg == ST_CLR) begin
                        res_load = 1'b1;
                        res_fail = STATUS_OK;
                    end
                end
            end
            ST_IDLE: begin
                if (s_xfer) begin
                    op_next = s_opcode;
                    id_next = s_node_id;
                    unique case (s_opcode)
                        OP_APPEND: begin
                            mem_re     = 1'b1;
                            state_next = ST_APND;
                        end
                        OP_REMOVE: begin
                            if (count_reg == '0) begin
                                res_load = 1'b1;
                            end else begin
                                // fetch membership and the node's own link
                                mem_re     = 1'b1;
                                ram_re     = 1'b1;
                                state_next = ST_LINK;
                            end
                        end
                        OP_SUCC: begin
                            mem_re     = 1'b1;
                            ram_re     = 1'b1;
                            state_next = ST_LINK;
                        end
                        OP_HEAD, OP_TAIL: begin
                            res_load = 1'b1;
                            if (count_reg != '0) begin
                                res_fail       = STATUS_OK;
                                res_node_valid = 1'b1;
                                res_node       = (s_opcode == OP_HEAD) ? head_reg : tail_reg;
                            end
                        end
                        OP_CLEAR: begin
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                            sweep_next = '0;
                            state_next = ST_CLR;
                        end
                        default: begin
                            // unused opcodes fail with no change
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_APND: begin
                res_load   = 1'b1;
                state_next = ST_IDLE;
                if (in_pool(id_reg) && !mem_rdata) begin
                    res_fail  = STATUS_OK;
                    mem_we    = 1'b1;
                    mem_wdata = 1'b1;
                    if (count_reg == '0) begin
                        head_next = id_reg;
                    end else if (in_pool(tail_reg)) begin
                        // old tail now links to the new node
                        ram_we = 1'b1;
                    end
                    tail_next  = id_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_LINK: begin
                if (!req_member) begin
                    // not on the list
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end else if (op_reg == OP_SUCC) begin
                    res_load   = 1'b1;
                    res_fail   = STATUS_OK;
                    state_next = ST_IDLE;
                    // tail has no successor
                    if (id_reg != tail_reg) begin
                        res_node_valid = 1'b1;
                        res_node       = ram_rdata;
                    end
                end else if (id_reg == head_reg) begin
                    // removing the head: its link becomes the new head
                    if (count_reg > CNT_W'(1)) begin
                        head_next = ram_rdata;
                    end
                    rm_done    = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    // start the predecessor search at the head
                    id_link_next = ram_rdata;
                    p_next       = head_reg;
                    steps_next   = '0;
                    state_next   = ST_WALK;
                end
            end
            ST_WALK: begin
                if (steps_reg < count_reg && p_reg != tail_reg) begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot_of(p_reg);
                    state_next = ST_CMP;
                end else begin
                    // chain ended without finding a predecessor
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CMP: begin
                if (ram_rdata == id_reg) begin
                    state_next = ST_IDLE;
                    if (!in_pool(p_reg)) begin
                        res_load = 1'b1;
                    end else begin
                        if (id_reg == tail_reg) begin
                            // tail removed: predecessor becomes the tail
                            tail_next = p_reg;
                        end else begin
                            // bypass the removed node
                            ram_we    = 1'b1;
                            ram_waddr = slot_of(p_reg);
                            ram_wdata = id_link_reg;
                        end
                        rm_done = 1'b1;
                    end
                end else begin
                    p_next     = ram_rdata;
                    steps_next = steps_reg + CNT_W'(1);
                    state_next = ST_WALK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // common tail of a successful removal
        if (rm_done) begin
            res_load   = 1'b1;
            res_fail   = STATUS_OK;
            mem_we     = 1'b1;
            mem_waddr  = slot_of(id_reg);
            mem_wdata  = 1'b0;
            count_next = count_reg - CNT_W'(1);
            if (count_next == '0) begin
                head_next = '0;
                tail_next = '0;
            end
        end

        // output register: load a new result, or drain on transfer
        m_valid_next          = m_valid_reg && !m_ready;
        m_status_next         = m_status_reg;
        m_node_out_next       = m_node_out_reg;
        m_node_out_valid_next = m_node_out_valid_reg;
        m_list_count_next     = m_list_count_reg;
        if (res_load) begin
            m_valid_next          = 1'b1;
            m_status_next         = res_fail;
            m_node_out_next       = res_node;
            m_node_out_valid_next = res_node_valid;
            m_list_count_next     = count_next;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and walk registers, no reset needed
    always_ff @(posedge aclk) begin
        op_reg               <= op_next;
        id_reg               <= id_next;
        p_reg                <= p_next;
        steps_reg            <= steps_next;
        id_link_reg          <= id_link_next;
        m_status_reg         <= m_status_next;
        m_node_out_reg       <= m_node_out_next;
        m_node_out_valid_reg <= m_node_out_valid_next;
        m_list_count_reg     <= m_list_count_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_node_out       = m_node_out_reg;
    assign m_node_out_valid = m_node_out_valid_reg;
    assign m_list_count     = m_list_count_reg;

    // count never exceeds the pool size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(NODE_SLOTS))
        else $error("list count above pool size");

    // link memory never read and written in the same cycle, so no forwarding is needed
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("link memory read and write overlap");

    // membership memory never read and written in the same cycle
    a_member_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("membership memory read and write overlap");

    // while an operation is in progress the output register is empty
    a_busy_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !m_valid_reg)
        else $error("result pending during a multi-cycle operation");

    // walk never runs past the list length
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK || state_reg == ST_CMP) |-> (steps_reg <= count_reg))
        else $error("walk exceeded list length");

    // an empty list reports empty head and tail
    a_empty_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty list with nonzero head or tail");

endmodule

`default_nettype wire
